// ===== hdl/pi_controller_antiwindup_assert.svh =====
// ----------------------------------------------------------------------------
// PI controller assertion macros
// Shared concurrent assertion forms used by the PI controller RTL.
// ----------------------------------------------------------------------------
`ifndef PI_CONTROLLER_ANTIWINDUP_ASSERT_SVH
`define PI_CONTROLLER_ANTIWINDUP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PI_AW_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PI_AW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pi_aw_pkg.sv =====
// ----------------------------------------------------------------------------
// PI controller package
// Widths, register indexes, mode bits and reset values of the PI controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pi_aw_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP             = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI_TS          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REF_LIMITS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDUP_LIMITS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT_UP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT_DOWN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REST_OUTPUT    = 3'd7;

    // Bit positions in the mode register.
    localparam int MODE_REF_CLAMP = 0;
    localparam int MODE_OUT_CLAMP = 1;
    localparam int MODE_FB_INVERT = 2;
    localparam int MODE_OUT_INV   = 3;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    localparam logic [CFG_DATA_W-1:0] LIMITS_RESET = 64'h7FFF_FFFF_8000_0000;

endpackage

`default_nettype wire

// ===== hdl/pi_controller_antiwindup.sv =====
// ----------------------------------------------------------------------------
// PI controller with anti-windup
// Fixed-point PI controller, one drive word per input word, full throughput.
// ----------------------------------------------------------------------------
// Usage:
// Input words (s_enable, s_reference, s_feedback) arrive on a valid/ready
// channel; one result word (m_drive, m_ref_limited, m_out_limited) leaves on
// the m_ channel for every input word, in order.
// The design is a three-register pipeline: input register, product register
// (both gain multiplies), result register. A word accepted into the input
// register passes through the product register to the result register and
// is then offered on m_valid. Throughput is one word per cycle while the
// receiver does not stall; the integrator add and clamp close in the last stage.
// Each stage has its own valid bit and takes a new word whenever it is empty
// or its word moves on, so a stalled receiver only blocks once all three
// registers are full; bubbles are squeezed out meanwhile.
// Synchronous active-low reset empties the pipeline, clears the integrator
// and both limit flags, and returns all configuration registers to their
// defaults. Configuration is written through cfg_wr_en/cfg_index/cfg_wdata
// and should only change while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pi_controller_antiwindup_assert.svh"

module pi_controller_antiwindup (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // configuration write port
    input  wire logic                                   cfg_wr_en,
    input  wire logic [pi_aw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [pi_aw_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // input word channel
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_enable,
    input  wire logic signed [pi_aw_pkg::DATA_W-1:0]    s_reference,
    input  wire logic signed [pi_aw_pkg::DATA_W-1:0]    s_feedback,
    // result word channel
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [pi_aw_pkg::DATA_W-1:0]         m_drive,
    output logic                                        m_ref_limited,
    output logic                                        m_out_limited
);

    localparam int W  = pi_aw_pkg::DATA_W;
    // Error is the exact difference of two words, one bit wider.
    localparam int EW = W + 1;
    // Full product of a gain and the error.
    localparam int PW = W + EW;
    // Fraction bits of the Q8.24 gains; dropping them floors the product.
    localparam int GAIN_FRAC = 24;
    // Width of a product after the gain fraction is dropped.
    localparam int TW = PW - GAIN_FRAC;
    // Width of the integrator and output sums, with room for the carry.
    localparam int AW = TW + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0]                             mode_reg;
    logic signed [W-1:0]                    kp_reg;
    logic signed [W-1:0]                    ki_ts_reg;
    logic [pi_aw_pkg::CFG_DATA_W-1:0]       ref_limits_reg;
    logic [pi_aw_pkg::CFG_DATA_W-1:0]       windup_limits_reg;
    logic signed [W-1:0]                    out_limit_up_reg;
    logic signed [W-1:0]                    out_limit_down_reg;
    logic signed [W-1:0]                    rest_output_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg           <= '0;
            kp_reg             <= '0;
            ki_ts_reg          <= '0;
            ref_limits_reg     <= pi_aw_pkg::LIMITS_RESET;
            windup_limits_reg  <= pi_aw_pkg::LIMITS_RESET;
            out_limit_up_reg   <= pi_aw_pkg::S32_MAX;
            out_limit_down_reg <= pi_aw_pkg::S32_MIN;
            rest_output_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pi_aw_pkg::REG_MODE:           mode_reg           <= cfg_wdata[3:0];
                pi_aw_pkg::REG_KP:             kp_reg             <= cfg_wdata[W-1:0];
                pi_aw_pkg::REG_KI_TS:          ki_ts_reg          <= cfg_wdata[W-1:0];
                pi_aw_pkg::REG_REF_LIMITS:     ref_limits_reg     <= cfg_wdata;
                pi_aw_pkg::REG_WINDUP_LIMITS:  windup_limits_reg  <= cfg_wdata;
                pi_aw_pkg::REG_OUT_LIMIT_UP:   out_limit_up_reg   <= cfg_wdata[W-1:0];
                pi_aw_pkg::REG_OUT_LIMIT_DOWN: out_limit_down_reg <= cfg_wdata[W-1:0];
                pi_aw_pkg::REG_REST_OUTPUT:    rest_output_reg    <= cfg_wdata[W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage loads when it is empty or its word
    // leaves in the same cycle.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic m_valid_reg;
    logic s1_ready;
    logic s2_ready;
    logic out_ready;
    logic adv1;
    logic adv2;
    logic adv3;

    assign out_ready = !m_valid_reg || m_ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_ready   = s1_ready;
    assign m_valid   = m_valid_reg;

    assign adv1 = s_valid && s1_ready;
    assign adv2 = s1_valid_reg && s2_ready;
    assign adv3 = s2_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic                s1_en_reg;
    logic signed [W-1:0] s1_ref_reg;
    logic signed [W-1:0] s1_fb_reg;

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s1_en_reg  <= s_enable;
            s1_ref_reg <= s_reference;
            s1_fb_reg  <= s_feedback;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 to 2: reference clamp, feedback inversion, error, windup window, products
    // ------------------------------------------------------------------
    logic signed [W-1:0]  ref_hi;
    logic signed [W-1:0]  ref_lo;
    logic                 ref_above;
    logic                 ref_below;
    logic signed [W-1:0]  ref_upper_cut;
    logic signed [W-1:0]  ref_used;
    logic signed [W-1:0]  fb_used;
    logic signed [EW-1:0] err;
    logic signed [EW-1:0] win_hi;
    logic signed [EW-1:0] win_lo;
    logic                 err_inside;
    logic signed [PW-1:0] p_prod;
    logic signed [PW-1:0] i_prod;
    logic                 ref_flag_reg;
    logic                 ref_flag_next;

    always_comb begin
        ref_hi        = $signed(ref_limits_reg[2*W-1:W]);
        ref_lo        = $signed(ref_limits_reg[W-1:0]);
        // The upper test comes first, so crossed limits settle on the lower one.
        ref_above     = s1_ref_reg > ref_hi;
        ref_upper_cut = ref_above ? ref_hi : s1_ref_reg;
        ref_below     = ref_upper_cut < ref_lo;
        ref_used      = s1_ref_reg;
        ref_flag_next = ref_flag_reg;
        if (s1_en_reg && mode_reg[pi_aw_pkg::MODE_REF_CLAMP]) begin
            ref_used      = ref_below ? ref_lo : ref_upper_cut;
            ref_flag_next = ref_above || ref_below;
        end

        fb_used = s1_fb_reg;
        if (mode_reg[pi_aw_pkg::MODE_FB_INVERT]) begin
            fb_used = (s1_fb_reg == pi_aw_pkg::S32_MIN) ? pi_aw_pkg::S32_MAX : -s1_fb_reg;
        end

        err = {ref_used[W-1], ref_used} - {fb_used[W-1], fb_used};

        win_hi     = {windup_limits_reg[2*W-1], windup_limits_reg[2*W-1:W]};
        win_lo     = {windup_limits_reg[W-1], windup_limits_reg[W-1:0]};
        err_inside = !(err > win_hi) && !(err < win_lo);

        p_prod = kp_reg * err;
        i_prod = ki_ts_reg * err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_flag_reg <= 1'b0;
        end else if (adv2) begin
            ref_flag_reg <= ref_flag_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: product register
    // ------------------------------------------------------------------
    logic                 s2_en_reg;
    logic signed [TW-1:0] s2_p_reg;
    logic signed [TW-1:0] s2_inc_reg;
    logic                 s2_ref_flag_reg;

    function automatic logic signed [TW-1:0] p_inc_sel(input logic signed [PW-1:0] prod);
        p_inc_sel = prod[PW-1:GAIN_FRAC];
    endfunction

    always_ff @(posedge aclk) begin
        if (adv2) begin
            s2_en_reg       <= s1_en_reg;
            s2_p_reg        <= p_prod[PW-1:GAIN_FRAC];
            s2_inc_reg      <= err_inside ? p_inc_sel(i_prod) : '0;
            s2_ref_flag_reg <= ref_flag_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 to 3: integrator, output sum, inversion and output clamp
    // ------------------------------------------------------------------
    logic signed [W-1:0]  integral_reg;
    logic signed [W-1:0]  integral_next;
    logic signed [AW-1:0] lim_up_ext;
    logic signed [AW-1:0] lim_dn_ext;
    logic signed [AW-1:0] acc_sum;
    logic signed [AW-1:0] acc_cut;
    logic signed [AW-1:0] acc_clamped;
    logic signed [AW-1:0] out_sum;
    logic signed [W-1:0]  drv_sat;
    logic signed [W-1:0]  drv_inv;
    logic signed [W-1:0]  drv_upper_cut;
    logic                 drv_above;
    logic                 drv_below;
    logic signed [W-1:0]  drive_next;
    logic                 out_flag_reg;
    logic                 out_flag_next;

    always_comb begin
        lim_up_ext  = AW'(out_limit_up_reg);
        lim_dn_ext  = AW'(out_limit_down_reg);

        acc_sum     = AW'(integral_reg) + AW'(s2_inc_reg);
        acc_cut     = (acc_sum > lim_up_ext) ? lim_up_ext : acc_sum;
        acc_clamped = (acc_cut < lim_dn_ext) ? lim_dn_ext : acc_cut;

        out_sum = AW'(s2_p_reg) + acc_clamped;
        if (out_sum > AW'(pi_aw_pkg::S32_MAX)) begin
            drv_sat = pi_aw_pkg::S32_MAX;
        end else if (out_sum < AW'(pi_aw_pkg::S32_MIN)) begin
            drv_sat = pi_aw_pkg::S32_MIN;
        end else begin
            drv_sat = out_sum[W-1:0];
        end

        drv_inv = drv_sat;
        if (mode_reg[pi_aw_pkg::MODE_OUT_INV]) begin
            drv_inv = (drv_sat == pi_aw_pkg::S32_MIN) ? pi_aw_pkg::S32_MAX : -drv_sat;
        end

        drv_above     = drv_inv > out_limit_up_reg;
        drv_upper_cut = drv_above ? out_limit_up_reg : drv_inv;
        drv_below     = drv_upper_cut < out_limit_down_reg;

        integral_next = integral_reg;
        out_flag_next = out_flag_reg;
        drive_next    = rest_output_reg;
        if (s2_en_reg) begin
            integral_next = acc_clamped[W-1:0];
            drive_next    = drv_inv;
            if (mode_reg[pi_aw_pkg::MODE_OUT_CLAMP]) begin
                drive_next    = drv_below ? out_limit_down_reg : drv_upper_cut;
                out_flag_next = drv_above || drv_below;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg <= '0;
            out_flag_reg <= 1'b0;
        end else if (adv3) begin
            integral_reg <= integral_next;
            out_flag_reg <= out_flag_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: result register
    // ------------------------------------------------------------------
    logic signed [W-1:0] m_drive_reg;
    logic                m_ref_lim_reg;
    logic                m_out_lim_reg;

    always_ff @(posedge aclk) begin
        if (adv3) begin
            m_drive_reg   <= drive_next;
            m_ref_lim_reg <= s2_ref_flag_reg;
            m_out_lim_reg <= out_flag_next;
        end
    end

    assign m_drive       = m_drive_reg;
    assign m_ref_limited = m_ref_lim_reg;
    assign m_out_limited = m_out_lim_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PI_AW_ASSERT_NEXT(a_integral_bounded, aclk, aresetn, adv3 && s2_en_reg,
        (integral_reg <= $past(out_limit_up_reg)) ||
        (integral_reg == $past(out_limit_down_reg)),
        "integrator left the output limits")
    `PI_AW_ASSERT_NEXT(a_integral_held, aclk, aresetn, !(adv3 && s2_en_reg),
        $stable(integral_reg), "integrator changed without an enabled word")
    `PI_AW_ASSERT_NEXT(a_drive_clamped, aclk, aresetn,
        adv3 && s2_en_reg && mode_reg[pi_aw_pkg::MODE_OUT_CLAMP],
        (m_drive <= $past(out_limit_up_reg)) || (m_drive == $past(out_limit_down_reg)),
        "clamped drive outside the output limits")
    `PI_AW_ASSERT_NEXT(a_rest_output, aclk, aresetn, adv3 && !s2_en_reg,
        m_valid && (m_drive == $past(rest_output_reg)),
        "disabled word did not give the rest output")

endmodule

`default_nettype wire
